[rtl/core/ssi_pkg.sv]
// shared types, widths and constants of the simpson stream integrator
// no dependencies; imported by every module of the block

package ssi_pkg;

    // field and port widths
    localparam int SAMPLE_W    = 32;
    localparam int STEP_W      = 32;
    localparam int COUNT_W     = 16;
    localparam int INTEGRAL_W  = 64;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    // run length limits
    localparam int MIN_SAMPLES = 3;
    localparam int MAX_SAMPLES = 65535;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE    = 4'd1;

    // register reset values
    localparam logic [COUNT_W-1:0]       COUNT_RESET = 16'd3;
    localparam logic signed [STEP_W-1:0] STEP_RESET  = 32'sd65536;

    // accumulator of 8*T + 9*E, magnitude and product split
    localparam int WEIGHT_W = 6;
    localparam int WPROD_W  = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACC_W    = 56;
    localparam int MAG_W    = ACC_W - 1;
    localparam int LO_W     = 32;
    localparam int HI_W     = MAG_W - LO_W;
    localparam int PLO_W    = LO_W + STEP_W;
    localparam int PHI_W    = HI_W + STEP_W;
    localparam int SUM_W    = PHI_W + LO_W + 1;

    // rounding and division by 24 (shift by 3, then divide by 3)
    localparam int ROUND_BIAS  = 12;
    localparam int DIV_SHIFT   = 3;
    localparam int DIV_BASE    = 3;
    localparam int DIV_DIGIT_W = 16;
    localparam int DIV_DIGITS  = 6;
    localparam int DIV_W       = DIV_DIGIT_W * DIV_DIGITS;
    localparam int DIV_REM_W   = 2;
    localparam int DIV_CUR_W   = DIV_REM_W + DIV_DIGIT_W;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 19;
    localparam int RECIP       = 349526;
    localparam int DIV_PROD_W  = DIV_CUR_W + RECIP_W;

    // saturation limits as magnitudes
    localparam logic [INTEGRAL_W-1:0] INT_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [INTEGRAL_W-1:0] INT_MIN_MAG = 64'h8000_0000_0000_0000;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // weight classes, scaled by 8 for the 1/3 rule and by 9 for the 3/8 rule
    typedef enum logic [2:0] {
        WC_END,
        WC_EVEN,
        WC_ODD,
        WC_SHARED,
        WC_TAIL_END,
        WC_TAIL_INNER
    } t_weight_class;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        t_weight_class              wclass;
        logic                       last;
    } t_ssi_item;

    // combined weight 8*w3 + 9*w8 of a class
    function automatic logic [WEIGHT_W-1:0] class_weight(input t_weight_class c);
        logic [WEIGHT_W-1:0] w;
        case (c)
            WC_END:        w = 6'd8;
            WC_EVEN:       w = 6'd16;
            WC_ODD:        w = 6'd32;
            WC_SHARED:     w = 6'd17;
            WC_TAIL_END:   w = 6'd9;
            WC_TAIL_INNER: w = 6'd27;
            default:       w = 6'd0;
        endcase
        return w;
    endfunction

endpackage

[rtl/core/ssi_front.sv]
// front end: configuration registers, sample index and weight classification
// depends on ssi_pkg

module ssi_front import ssi_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic signed [SAMPLE_W-1:0]    i_sample,
    input  logic                          i_q_full,
    output logic                          o_full,
    output logic                          o_wr,
    output t_ssi_item                     o_item,
    input  logic                          i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    output logic                          o_cfg_ready,
    output logic signed [STEP_W-1:0]      o_step,
    output logic                          o_clear
);

    logic [COUNT_W-1:0]       r_count;
    logic signed [STEP_W-1:0] r_step;
    logic [COUNT_W-1:0]       r_index;

    logic [COUNT_W-1:0] count_eff;
    logic [COUNT_W-1:0] last_idx;
    logic [COUNT_W-1:0] tail_start;
    logic               is_last;
    t_weight_class      wclass;
    logic               cfg_we;

    // effective run length after clamping
    always_comb begin
        if (r_count < COUNT_W'(MIN_SAMPLES)) begin
            count_eff = COUNT_W'(MIN_SAMPLES);
        end else if (32'(r_count) > MAX_SAMPLES) begin
            count_eff = COUNT_W'(MAX_SAMPLES);
        end else begin
            count_eff = r_count;
        end
    end

    assign last_idx   = count_eff - 16'd1;
    assign tail_start = count_eff - 16'd4;
    assign is_last    = (r_index >= last_idx);

    // classify the current sample position
    always_comb begin
        if (count_eff[0]) begin
            if (r_index == '0 || r_index == last_idx) begin
                wclass = WC_END;
            end else begin
                wclass = r_index[0] ? WC_ODD : WC_EVEN;
            end
        end else if (r_index < tail_start) begin
            if (r_index == '0) begin
                wclass = WC_END;
            end else begin
                wclass = r_index[0] ? WC_ODD : WC_EVEN;
            end
        end else if (r_index == tail_start) begin
            // four samples: the 1/3 part is empty
            wclass = (tail_start == '0) ? WC_TAIL_END : WC_SHARED;
        end else if (r_index == last_idx) begin
            wclass = WC_TAIL_END;
        end else begin
            wclass = WC_TAIL_INNER;
        end
    end

    // input transaction and queue item
    assign o_full        = i_q_full;
    assign o_wr          = i_push && !i_q_full;
    assign o_item.sample = i_sample;
    assign o_item.wclass = wclass;
    assign o_item.last   = is_last;

    // configuration writes
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign o_clear     = cfg_we &&
                         (i_cfg_index == REG_SAMPLE_COUNT || i_cfg_index == REG_STEP_SIZE);
    assign o_step      = r_step;

    // registers and run index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
            r_step  <= STEP_RESET;
            r_index <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_SAMPLE_COUNT: begin
                    r_count <= i_cfg_data[COUNT_W-1:0];
                    r_index <= '0;
                end
                REG_STEP_SIZE: begin
                    r_step  <= $signed(i_cfg_data[STEP_W-1:0]);
                    r_index <= '0;
                end
                default: begin
                end
            endcase
        end else if (o_wr) begin
            r_index <= is_last ? '0 : r_index + 16'd1;
        end
    end

    // the index always stays inside the run
    a_index_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index < count_eff)
        else $error("sample index outside the run");

endmodule

[rtl/core/ssi_queue.sv]
// short queue of classified samples between front and back
// depends on ssi_pkg

module ssi_queue import ssi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr,
    input  t_ssi_item i_item,
    input  logic      i_rd,
    output t_ssi_item o_item,
    output logic      o_full,
    output logic      o_empty
);

    t_ssi_item             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wptr;
    logic [QUEUE_AW-1:0]   r_rptr;
    logic [QUEUE_AW:0]     r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_item  = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // pointers apart means a partly filled queue
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wptr != r_rptr) |-> (!o_empty && !o_full))
        else $error("queue pointers disagree with fill count");

endmodule

[rtl/core/ssi_back.sv]
// back end: weighted accumulation, scaling by step/24 with rounding,
// division pipeline and saturation into the output register; depends on ssi_pkg

module ssi_back import ssi_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ssi_item                   i_item,
    input  logic                        i_item_valid,
    output logic                        o_item_rd,
    input  logic signed [STEP_W-1:0]    i_step,
    input  logic                        i_clear,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic signed [INTEGRAL_W-1:0] o_integral,
    output logic                        o_saturated
);

    // accumulator and stage registers
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_v1;
    logic signed [ACC_W-1:0] r_s1;
    logic                    r_v2, r_neg2;
    logic [MAG_W-1:0]        r_ms2;
    logic [STEP_W-1:0]       r_mh2;
    logic                    r_v3, r_neg3;
    logic [HI_W-1:0]         r_mshi3;
    logic [STEP_W-1:0]       r_mh3;
    logic [PLO_W-1:0]        r_plo3;
    logic                    r_v4, r_neg4;
    logic [PLO_W-1:0]        r_plo4;
    logic [PHI_W-1:0]        r_phi4;
    logic                    r_dv   [DIV_DIGITS+1];
    logic                    r_dneg [DIV_DIGITS+1];
    logic [DIV_W-1:0]        r_dw   [DIV_DIGITS+1];
    logic [DIV_REM_W-1:0]    r_dr   [DIV_DIGITS+1];
    logic                    r_out_valid;
    logic [INTEGRAL_W-1:0]   r_out_integral;
    logic                    r_out_sat;

    logic                     en;
    logic                     take;
    logic [WEIGHT_W-1:0]      weight;
    logic signed [WPROD_W-1:0] wprod;
    logic signed [ACC_W-1:0]  acc_sum;
    logic [ACC_W-1:0]         s_mag;
    logic [STEP_W-1:0]        h_mag;
    logic [PLO_W-1:0]         plo;
    logic [PHI_W-1:0]         phi;
    logic [SUM_W-1:0]         rsum;
    logic [DIV_W-1:0]         dw_first;
    logic [DIV_CUR_W-1:0]     d_cur  [DIV_DIGITS];
    logic [DIV_PROD_W-1:0]    d_prod [DIV_DIGITS];
    logic [DIV_DIGIT_W-1:0]   d_q    [DIV_DIGITS];
    logic [DIV_CUR_W-1:0]     d_rem  [DIV_DIGITS];
    logic [DIV_W-1:0]         d_nw   [DIV_DIGITS];
    logic [DIV_W-1:0]         lim;
    logic                     sat;
    logic [INTEGRAL_W-1:0]    mag;
    logic [INTEGRAL_W-1:0]    res;

    // the whole back end moves when the output register can take a result
    assign en        = !r_out_valid || i_pop;
    assign take      = en && i_item_valid;
    assign o_item_rd = take;

    // weighted add of one sample
    assign weight  = class_weight(i_item.wclass);
    assign wprod   = i_item.sample * $signed({1'b0, weight});
    assign acc_sum = r_acc + {{(ACC_W-WPROD_W){wprod[WPROD_W-1]}}, wprod};

    // sign and magnitudes of sum and step
    assign s_mag = r_s1[ACC_W-1] ? (~r_s1 + 1'b1) : r_s1;
    assign h_mag = i_step[STEP_W-1] ? (~i_step + 1'b1) : i_step;

    // partial products of |s| * |h|
    assign plo = r_ms2[LO_W-1:0] * r_mh2;
    assign phi = r_mshi3 * r_mh3;

    // rounding bias, then divide by 8
    assign rsum     = {1'b0, r_phi4, {LO_W{1'b0}}} + SUM_W'(r_plo4) + SUM_W'(ROUND_BIAS);
    assign dw_first = DIV_W'(rsum >> DIV_SHIFT);

    // one quotient digit of the division by 3 per stage
    always_comb begin
        for (int k = 0; k < DIV_DIGITS; k++) begin
            d_cur[k]  = {r_dr[k], r_dw[k][DIV_W-1-DIV_DIGIT_W*k -: DIV_DIGIT_W]};
            d_prod[k] = DIV_PROD_W'(d_cur[k]) * DIV_PROD_W'(RECIP);
            d_q[k]    = d_prod[k][RECIP_SHIFT +: DIV_DIGIT_W];
            d_rem[k]  = d_cur[k] - DIV_CUR_W'(d_q[k]) * DIV_CUR_W'(DIV_BASE);
            d_nw[k]   = r_dw[k];
            d_nw[k][DIV_W-1-DIV_DIGIT_W*k -: DIV_DIGIT_W] = d_q[k];
        end
    end

    // saturation and sign of the quotient
    always_comb begin
        lim = r_dneg[DIV_DIGITS] ? DIV_W'(INT_MIN_MAG) : DIV_W'(INT_MAX);
        sat = (r_dw[DIV_DIGITS] > lim);
        mag = sat ? lim[INTEGRAL_W-1:0] : r_dw[DIV_DIGITS][INTEGRAL_W-1:0];
        res = r_dneg[DIV_DIGITS] ? (~mag + 1'b1) : mag;
    end

    // accumulator and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= DIV_DIGITS; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else begin
            if (i_clear) begin
                r_acc <= '0;
            end else if (take) begin
                r_acc <= i_item.last ? '0 : acc_sum;
            end
            if (en) begin
                r_v1        <= take && i_item.last;
                r_v2        <= r_v1;
                r_v3        <= r_v2;
                r_v4        <= r_v3;
                r_dv[0]     <= r_v4;
                for (int k = 0; k < DIV_DIGITS; k++) begin
                    r_dv[k+1] <= r_dv[k];
                end
                r_out_valid <= r_dv[DIV_DIGITS];
            end
        end
    end

    // payload of the stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1    <= acc_sum;
            r_neg2  <= r_s1[ACC_W-1] ^ i_step[STEP_W-1];
            r_ms2   <= s_mag[MAG_W-1:0];
            r_mh2   <= h_mag;
            r_neg3  <= r_neg2;
            r_mshi3 <= r_ms2[MAG_W-1:LO_W];
            r_mh3   <= r_mh2;
            r_plo3  <= plo;
            r_neg4  <= r_neg3;
            r_plo4  <= r_plo3;
            r_phi4  <= phi;
            r_dneg[0] <= r_neg4;
            r_dw[0]   <= dw_first;
            r_dr[0]   <= '0;
            for (int k = 0; k < DIV_DIGITS; k++) begin
                r_dneg[k+1] <= r_dneg[k];
                r_dw[k+1]   <= d_nw[k];
                r_dr[k+1]   <= d_rem[k][DIV_REM_W-1:0];
            end
            r_out_integral <= res;
            r_out_sat      <= sat;
        end
    end

    assign o_empty     = !r_out_valid;
    assign o_integral  = $signed(r_out_integral);
    assign o_saturated = r_out_sat;

    // a clipped result is one of the two limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |->
        (r_out_integral == INT_MAX || r_out_integral == INT_MIN_MAG))
        else $error("saturated result is not a limit");

    // the last sample of a run leaves a cleared accumulator
    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_item.last) |=> (r_acc == '0))
        else $error("accumulator not cleared after a run");

    // the division remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv[DIV_DIGITS] |-> (r_dr[DIV_DIGITS] < DIV_REM_W'(DIV_BASE)))
        else $error("division remainder out of range");

endmodule

[rtl/core/simpson_stream_integrator.sv]
// top level of the simpson stream integrator: front, queue and back end
// depends on ssi_pkg, ssi_front, ssi_queue and ssi_back
//
// usage
//   samples (signed Q16.16) go in through push/full, one transaction per
//   cycle while full is low. after sample_count samples one integral
//   (signed Q32.32, saturated, with a clip flag) appears at the result
//   side; it is shown while empty is low and taken with pop.
//   odd counts use the 1/3 rule, even counts end with a 3/8 tail.
//   configuration: write sample_count (index 0) or step_size (index 1)
//   on the cfg channel while the block is idle; a write clears the run.
//   throughput: one sample per cycle unless stalled (single accumulate stage).
//   path: after the transaction of the last sample of a run the result
//   passes the queue, accumulate, sign and magnitude, two multiply
//   stages, round, six division digit stages and the output register.
//   reset: synchronous, active low; the run and all queues are cleared,
//   sample_count returns to 3 and step_size to 1.0.
//   when the receiver stalls the back end holds, the four-entry queue
//   fills and full rises; nothing is lost.

module simpson_stream_integrator import ssi_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [SAMPLE_W-1:0]   i_sample,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [INTEGRAL_W-1:0] o_integral,
    output logic                         o_saturated,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    logic                     q_wr;
    logic                     q_rd;
    logic                     q_full;
    logic                     q_empty;
    t_ssi_item                q_in;
    t_ssi_item                q_out;
    logic signed [STEP_W-1:0] step;
    logic                     clear;

    // classification and configuration
    ssi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_sample    (i_sample),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_wr        (q_wr),
        .o_item      (q_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_step      (step),
        .o_clear     (clear)
    );

    // decoupling queue
    ssi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_item  (q_in),
        .i_rd    (q_rd),
        .o_item  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // accumulation and scaling
    ssi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_out),
        .i_item_valid (!q_empty),
        .o_item_rd    (q_rd),
        .i_step       (step),
        .i_clear      (clear),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_integral   (o_integral),
        .o_saturated  (o_saturated)
    );

endmodule
